// ===== hw/rtl/bnp_pkg.sv =====
package bnp_pkg;

  // Store depth and derived widths
  localparam int MAX_DIGITS = 32;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W      = 6;
  localparam int VALUE_W    = 31;
  localparam int DIGIT_W    = 6;
  localparam int RADIX_W    = 6;
  localparam int RECIP_W    = 32;
  localparam int PROD_W     = VALUE_W + RECIP_W;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_RD,
    ST_CMP,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic fix;
    logic rd;
    logic cmp;
    logic pub;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic quot_zero;
    logic pairs_done;
    logic mismatch;
  } status_t;

  // Clamp the radix register into the supported range
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] e;
    if (r < RADIX_MIN) begin
      e = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      e = RADIX_MAX;
    end else begin
      e = r;
    end
    return e;
  endfunction

  // floor(2^32 / radix); the quotient estimate is then exact or one short
  function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      6'd2:    m = 32'd2147483648;
      6'd3:    m = 32'd1431655765;
      6'd4:    m = 32'd1073741824;
      6'd5:    m = 32'd858993459;
      6'd6:    m = 32'd715827882;
      6'd7:    m = 32'd613566756;
      6'd8:    m = 32'd536870912;
      6'd9:    m = 32'd477218588;
      6'd10:   m = 32'd429496729;
      6'd11:   m = 32'd390451572;
      6'd12:   m = 32'd357913941;
      6'd13:   m = 32'd330382099;
      6'd14:   m = 32'd306783378;
      6'd15:   m = 32'd286331153;
      6'd16:   m = 32'd268435456;
      6'd17:   m = 32'd252645135;
      6'd18:   m = 32'd238609294;
      6'd19:   m = 32'd226050910;
      6'd20:   m = 32'd214748364;
      6'd21:   m = 32'd204522252;
      6'd22:   m = 32'd195225786;
      6'd23:   m = 32'd186737708;
      6'd24:   m = 32'd178956970;
      6'd25:   m = 32'd171798691;
      6'd26:   m = 32'd165191049;
      6'd27:   m = 32'd159072862;
      6'd28:   m = 32'd153391689;
      6'd29:   m = 32'd148102320;
      6'd30:   m = 32'd143165576;
      6'd31:   m = 32'd138547332;
      6'd32:   m = 32'd134217728;
      6'd33:   m = 32'd130150524;
      6'd34:   m = 32'd126322567;
      6'd35:   m = 32'd122713351;
      6'd36:   m = 32'd119304647;
      default: m = 32'd429496729;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/bnp_ctrl.sv =====
module bnp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  bnp_pkg::status_t status,
  output bnp_pkg::cmd_t    cmd
);
  import bnp_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_FIX;
      ST_FIX: begin
        state_nxt = status.quot_zero ? ST_RD : ST_MUL;
      end
      ST_RD: begin
        state_nxt = status.pairs_done ? ST_DONE : ST_CMP;
      end
      ST_CMP: begin
        state_nxt = status.mismatch ? ST_DONE : ST_RD;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_FIX:  cmd.fix = 1'b1;
      ST_RD:   cmd.rd  = !status.pairs_done;
      ST_CMP:  cmd.cmp = 1'b1;
      ST_DONE: cmd.pub = out_free;
      default: cmd     = '0;
    endcase
  end

  // Hold the result valid until the transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.pub) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/bnp_dp.sv =====
module bnp_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bnp_pkg::RADIX_W-1:0]        cfg_wdata,
  input  logic [bnp_pkg::IN_DATA_W-1:0]      in_tdata,
  input  bnp_pkg::cmd_t                      cmd,
  output bnp_pkg::status_t                   status,
  output logic [bnp_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import bnp_pkg::*;

  logic [RADIX_W-1:0]  radix_r;
  logic [RADIX_W-1:0]  base_r;
  logic [RECIP_W-1:0]  recip_r;
  logic [VALUE_W-1:0]  rest_r;
  logic [PROD_W-1:0]   prod_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    pair_r;
  logic                ovf_r;
  logic                sym_r;
  logic [DIGIT_W-1:0]  rd_lo_r;
  logic [DIGIT_W-1:0]  rd_hi_r;
  logic                pal_out_r;
  logic [CNT_W-1:0]    cnt_out_r;

  logic [DIGIT_W-1:0]  store_mem [MAX_DIGITS];

  logic [VALUE_W-1:0]          q_est;
  logic [VALUE_W+RADIX_W-1:0]  q_mul;
  logic [RADIX_W:0]            rem_raw;
  logic                        rem_fix;
  logic [RADIX_W:0]            rem;
  logic [VALUE_W-1:0]          quot;
  logic                        store_ok;
  logic [CNT_W-1:0]            hi_idx;

  // Radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  // Correct the quotient estimate with one compare and subtract
  assign q_est   = prod_r[PROD_W-1:RECIP_W];
  assign q_mul   = {{RADIX_W{1'b0}}, q_est} * {{VALUE_W{1'b0}}, base_r};
  assign rem_raw = rest_r[RADIX_W:0] - q_mul[RADIX_W:0];
  assign rem_fix = rem_raw >= {1'b0, base_r};
  assign rem     = rem_fix ? rem_raw - {1'b0, base_r} : rem_raw;
  assign quot    = q_est + {{(VALUE_W-1){1'b0}}, rem_fix};

  assign store_ok = 32'(count_r) < MAX_DIGITS;
  assign hi_idx   = count_r - 1'b1 - pair_r;

  assign status.quot_zero  = quot == '0;
  assign status.pairs_done = ovf_r || (pair_r >= (count_r >> 1));
  assign status.mismatch   = rd_lo_r != rd_hi_r;

  // Digit extraction and pair compare
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r  <= eff_radix(radix_r);
      recip_r <= recip(eff_radix(radix_r));
      rest_r  <= in_tdata[VALUE_W-1:0];
      count_r <= '0;
      pair_r  <= '0;
      ovf_r   <= 1'b0;
      sym_r   <= 1'b1;
    end
    if (cmd.mul) begin
      prod_r <= {{RECIP_W{1'b0}}, rest_r} * {{VALUE_W{1'b0}}, recip_r};
    end
    if (cmd.fix) begin
      rest_r  <= quot;
      count_r <= count_r + 1'b1;
      if (!store_ok) ovf_r <= 1'b1;
    end
    if (cmd.cmp) begin
      pair_r <= pair_r + 1'b1;
      if (status.mismatch) sym_r <= 1'b0;
    end
    if (cmd.pub) begin
      pal_out_r <= sym_r && !ovf_r;
      cnt_out_r <= count_r;
    end
  end

  // Digit store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.fix && store_ok) begin
      store_mem[count_r[ADDR_W-1:0]] <= rem[DIGIT_W-1:0];
    end
    if (cmd.rd) begin
      rd_lo_r <= store_mem[pair_r[ADDR_W-1:0]];
      rd_hi_r <= store_mem[hi_idx[ADDR_W-1:0]];
    end
  end

  assign out_tdata = {1'b0, cnt_out_r, pal_out_r};

endmodule

// ===== hw/rtl/base_n_palindrome_check_unit.sv =====
// Channel | Handshake          | Payload (lowest bit up)
// in      | in_tvalid/tready   | in_tdata: value[30:0], zero pad
// out     | out_tvalid/tready  | out_tdata: is_palindrome, digit_count[5:0], zero pad
// cfg     | cfg_we             | cfg_wdata: radix[5:0]
//
// One item at a time: each digit takes a reciprocal multiply, then a correct and
// store step; each mirrored pair is read from the digit store, then compared;
// the last pair check, the publish and the accept follow. The check ends early
// when a pair differs.
// Reset (synchronous, active low) sets radix to 10 and empties the result stage.
// A waiting result does not block the next accept; a finished item holds until
// the output register is free.
module base_n_palindrome_check_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bnp_pkg::IN_DATA_W-1:0]      in_tdata,   // value[30:0], pad
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bnp_pkg::OUT_DATA_W-1:0]     out_tdata,  // is_palindrome, digit_count, pad
  input  logic                               cfg_we,
  input  logic [bnp_pkg::RADIX_W-1:0]        cfg_wdata   // radix
);
  import bnp_pkg::*;

  cmd_t    cmd;
  status_t status;

  bnp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  bnp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule
